/* rtl/qmm_pkg.sv */
package qmm_pkg;

	localparam int DUTY_BITS     = 8;
	localparam int CTL_FRAC_BITS = 4;

	localparam int CTL_W      = 16;
	localparam int LIM_W      = 8;
	localparam int SHARE_W    = 9;
	localparam int KNEE_W     = 6;
	localparam int TRIM_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// three signed controls plus a trim shifted by up to 8 fraction bits
	localparam int MIX_W = CTL_W + 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOTOR_LIMIT  = 3'd0,
		CFG_THRUST_SHARE = 3'd1,
		CFG_KNEE_POINT   = 3'd2,
		CFG_OFFSET_FL    = 3'd3,
		CFG_OFFSET_FR    = 3'd4,
		CFG_OFFSET_RR    = 3'd5,
		CFG_OFFSET_RL    = 3'd6
	} cfg_reg_t;

	localparam logic [LIM_W-1:0]          RST_MOTOR_LIMIT  = 8'd255;
	localparam logic [SHARE_W-1:0]        RST_THRUST_SHARE = 9'd166;
	localparam logic [KNEE_W-1:0]         RST_KNEE_POINT   = 6'd40;
	localparam logic signed [TRIM_W-1:0]  RST_OFFSET_FL    = 7'sd22;
	localparam logic signed [TRIM_W-1:0]  RST_OFFSET_FR    = 7'sd0;
	localparam logic signed [TRIM_W-1:0]  RST_OFFSET_RR    = 7'sd23;
	localparam logic signed [TRIM_W-1:0]  RST_OFFSET_RL    = 7'sd32;

	typedef struct packed {
		logic                    armed;
		logic [7:0]              thrust_cmd;
		logic signed [CTL_W-1:0] roll_ctl;
		logic signed [CTL_W-1:0] pitch_ctl;
		logic signed [CTL_W-1:0] yaw_ctl;
	} mix_cmd_t;

	typedef struct packed {
		logic [DUTY_BITS-1:0] duty_zero;
		logic [DUTY_BITS-1:0] duty_one;
		logic [DUTY_BITS-1:0] duty_two;
		logic [DUTY_BITS-1:0] duty_three;
	} mix_duty_t;

endpackage

/* rtl/quad_motor_mixer.sv */
// channel | valid      | stall      | payload
// --------+------------+------------+--------------------------------
// command | cmd_valid  | cmd_stall  | cmd  (mix_cmd_t)
// duty    | duty_valid | duty_stall | duty (mix_duty_t)
// config  | cfg_we     | -          | cfg_index, cfg_wdata
//
// One item per cycle sustained while duty_stall stays low; duty_valid rises when the item reaches the output register.
// Depth is set by the knee-curve divider over (limit - knee): eight
// restoring stages, one quotient bit each.
// Reset clears all stage valid bits and loads the default register values.
// A stalled duty item holds; empty stages still fill behind it, and
// cmd_stall rises only once every stage holds an item.
module quad_motor_mixer import qmm_pkg::*; #(
	parameter int FRAC_BITS = CTL_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  mix_cmd_t              cmd,
	output logic                  duty_valid,
	input  logic                  duty_stall,
	output mix_duty_t             duty,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int DIV_STEPS = 8;
	localparam int PROD_W    = 19;
	localparam int NUM_W     = PROD_W + 1;
	localparam int TPROD_W   = LIM_W + SHARE_W;

	typedef struct packed {
		logic                     armed;
		logic                     lt;
		logic                     deg;
		logic [LIM_W-1:0]         t3;
		logic signed [PROD_W-1:0] prod;
	} s2_t;

	typedef struct packed {
		logic                      armed;
		logic                      lt;
		logic                      deg;
		logic                      neg;
		logic                      sat;
		logic [LIM_W-1:0]          t3;
		logic [LIM_W-1:0]          rem;
		logic [LIM_W-1:0]          low;
		logic [LIM_W-1:0]          quo;
		logic [3:0][LIM_W-1:0]     mc;
	} dv_t;

	typedef struct packed {
		logic                  armed;
		logic                  zero;
		logic [TPROD_W-1:0]    prod;
		logic [3:0][LIM_W-1:0] mc;
	} m_t;

	// config registers
	logic [LIM_W-1:0]         lim_q;
	logic [SHARE_W-1:0]       share_q;
	logic [KNEE_W-1:0]        knee_q;
	logic signed [TRIM_W-1:0] trim_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q     <= RST_MOTOR_LIMIT;
			share_q   <= RST_THRUST_SHARE;
			knee_q    <= RST_KNEE_POINT;
			trim_q[0] <= RST_OFFSET_FL;
			trim_q[1] <= RST_OFFSET_FR;
			trim_q[2] <= RST_OFFSET_RR;
			trim_q[3] <= RST_OFFSET_RL;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MOTOR_LIMIT:  lim_q     <= cfg_wdata[LIM_W-1:0];
				CFG_THRUST_SHARE: share_q   <= cfg_wdata[SHARE_W-1:0];
				CFG_KNEE_POINT:   knee_q    <= cfg_wdata[KNEE_W-1:0];
				CFG_OFFSET_FL:    trim_q[0] <= $signed(cfg_wdata[TRIM_W-1:0]);
				CFG_OFFSET_FR:    trim_q[1] <= $signed(cfg_wdata[TRIM_W-1:0]);
				CFG_OFFSET_RR:    trim_q[2] <= $signed(cfg_wdata[TRIM_W-1:0]);
				CFG_OFFSET_RL:    trim_q[3] <= $signed(cfg_wdata[TRIM_W-1:0]);
				default: ;
			endcase
		end
	end

	// values derived from config, refreshed every cycle
	logic [LIM_W-1:0]       knee3_d, den_d, den_q, ctl_lim_d, ctl_lim_q;
	logic                   cfg_deg;
	logic [15:0]            c3k_d, c3k_q;
	logic signed [9:0]      a_d, a_q;
	logic [TPROD_W-1:0]     tmax_prod, ctl_prod;
	logic [SHARE_W-1:0]     inv_share;
	logic [SHARE_W-1:0]     thr_max_q;

	always_comb begin
		knee3_d   = {1'b0, knee_q, 1'b0} + {2'b0, knee_q};
		den_d     = lim_q - {2'b0, knee_q};
		cfg_deg   = lim_q <= {2'b0, knee_q};
		c3k_d     = cfg_deg ? '0 : knee3_d * den_d;
		a_d       = $signed({2'b0, lim_q}) - $signed({2'b0, knee3_d});
		tmax_prod = lim_q * share_q;
		inv_share = 9'd256 - share_q;
		ctl_prod  = lim_q * inv_share;
		// share above one leaves no room for the controls
		ctl_lim_d = (share_q > 9'd256) ? '0 : ctl_prod[15:8];
	end

	always_ff @(posedge clk) begin
		den_q     <= den_d;
		c3k_q     <= c3k_d;
		a_q       <= a_d;
		thr_max_q <= tmax_prod[TPROD_W-1:8];
		ctl_lim_q <= ctl_lim_d;
	end

	// stage valids and enables
	logic                 v_s1, v_s2, v_m_s11, v_o_s12;
	logic [DIV_STEPS-1:0] v_div_s;
	logic                 en1, en2, en_m, en_o;
	logic [DIV_STEPS-1:0] en_div;

	always_comb begin
		en_o = !v_o_s12 || !duty_stall;
		en_m = !v_m_s11 || en_o;
		en_div[DIV_STEPS-1] = !v_div_s[DIV_STEPS-1] || en_m;
		for (int k = DIV_STEPS - 2; k >= 0; k--)
			en_div[k] = !v_div_s[k] || en_div[k+1];
		en2 = !v_s2 || en_div[0];
		en1 = !v_s1 || en2;
	end

	assign cmd_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_div_s <= '0;
			v_m_s11 <= 1'b0;
			v_o_s12 <= 1'b0;
		end else begin
			if (en1) v_s1 <= cmd_valid;
			if (en2) v_s2 <= v_s1;
			if (en_div[0]) v_div_s[0] <= v_s2;
			for (int k = 1; k < DIV_STEPS; k++)
				if (en_div[k]) v_div_s[k] <= v_div_s[k-1];
			if (en_m) v_m_s11 <= v_div_s[DIV_STEPS-1];
			if (en_o) v_o_s12 <= v_m_s11;
		end
	end

	// stage 1: registered command
	mix_cmd_t cmd_s1;

	always_ff @(posedge clk) begin
		if (en1) cmd_s1 <= cmd;
	end

	logic signed [8:0]        b1;
	logic signed [MIX_W-1:0]  r_x, p_x, y_x;
	logic signed [MIX_W-1:0]  tr_x [4];
	logic signed [MIX_W-1:0]  mix_d [4];
	s2_t                      s2_d;

	always_comb begin
		b1 = $signed({1'b0, cmd_s1.thrust_cmd}) - $signed({3'b0, knee_q});
		s2_d.armed = cmd_s1.armed;
		s2_d.lt    = {2'b0, knee_q} > cmd_s1.thrust_cmd;
		s2_d.deg   = cfg_deg;
		s2_d.t3    = LIM_W'({cmd_s1.thrust_cmd, 1'b0} + {1'b0, cmd_s1.thrust_cmd});
		s2_d.prod  = a_q * b1;
		r_x = MIX_W'(cmd_s1.roll_ctl);
		p_x = MIX_W'(cmd_s1.pitch_ctl);
		y_x = MIX_W'(cmd_s1.yaw_ctl);
		for (int i = 0; i < 4; i++)
			tr_x[i] = MIX_W'(trim_q[i]) <<< FRAC_BITS;
		mix_d[0] =  r_x - p_x - y_x + tr_x[0];
		mix_d[1] =  r_x + p_x + y_x + tr_x[1];
		mix_d[2] = -r_x + p_x - y_x + tr_x[2];
		mix_d[3] = -r_x - p_x + y_x + tr_x[3];
	end

	// stage 2: knee product and raw mixes
	s2_t                     s2;
	logic signed [MIX_W-1:0] mix_s2 [4];

	always_ff @(posedge clk) begin
		if (en2) begin
			s2 <= s2_d;
			for (int i = 0; i < 4; i++)
				mix_s2[i] <= mix_d[i];
		end
	end

	function automatic dv_t div_step(input dv_t d, input logic [LIM_W-1:0] den);
		logic [LIM_W:0] trial;
		logic           ge;
		dv_t            r;
		trial = {d.rem, d.low[LIM_W-1]};
		ge    = trial >= {1'b0, den};
		r     = d;
		r.rem = ge ? LIM_W'(trial - {1'b0, den}) : trial[LIM_W-1:0];
		r.low = {d.low[LIM_W-2:0], 1'b0};
		r.quo = {d.quo[LIM_W-2:0], ge};
		return r;
	endfunction

	logic signed [NUM_W-1:0] num;
	logic [MIX_W-1:0]        mshift [4];
	dv_t                     dv_init;

	always_comb begin
		num = NUM_W'(s2.prod) + $signed({4'b0, c3k_q});
		dv_init.armed = s2.armed;
		dv_init.lt    = s2.lt;
		dv_init.deg   = s2.deg;
		dv_init.t3    = s2.t3;
		// a negative curve always ends as zero thrust
		dv_init.neg   = num[NUM_W-1];
		// quotient of 256 or more saturates to the limit
		dv_init.sat   = num[16:8] >= {1'b0, den_q};
		dv_init.rem   = num[15:8];
		dv_init.low   = num[7:0];
		dv_init.quo   = '0;
		for (int i = 0; i < 4; i++) begin
			mshift[i] = $unsigned(mix_s2[i] >>> FRAC_BITS);
			if (mix_s2[i][MIX_W-1])
				dv_init.mc[i] = '0;
			else if (mshift[i] > {{(MIX_W-LIM_W){1'b0}}, ctl_lim_q})
				dv_init.mc[i] = ctl_lim_q;
			else
				dv_init.mc[i] = mshift[i][LIM_W-1:0];
		end
	end

	// stages 3 to 10: restoring divider
	dv_t div_s [DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en_div[0]) div_s[0] <= div_step(dv_init, den_q);
		for (int k = 1; k < DIV_STEPS; k++)
			if (en_div[k]) div_s[k] <= div_step(div_s[k-1], den_q);
	end

	dv_t              dl;
	logic [LIM_W-1:0] curve;
	m_t               m_d;

	always_comb begin
		dl = div_s[DIV_STEPS-1];
		if (dl.lt)
			curve = dl.t3;
		else if (dl.deg || dl.sat)
			curve = lim_q;
		else
			curve = dl.quo;
		m_d.armed = dl.armed;
		m_d.zero  = !dl.lt && !dl.deg && dl.neg;
		m_d.prod  = curve * share_q;
		m_d.mc    = dl.mc;
	end

	// stage 11: thrust product
	m_t m_s11;

	always_ff @(posedge clk) begin
		if (en_m) m_s11 <= m_d;
	end

	logic [SHARE_W-1:0]           thr;
	logic [SHARE_W:0]             sum [4];
	logic [3:0][DUTY_BITS-1:0]    dut;
	mix_duty_t                    duty_d;

	always_comb begin
		if (m_s11.zero)
			thr = '0;
		else if (m_s11.prod[TPROD_W-1:8] > thr_max_q)
			thr = thr_max_q;
		else
			thr = m_s11.prod[TPROD_W-1:8];
		for (int i = 0; i < 4; i++) begin
			sum[i] = {2'b0, m_s11.mc[i]} + {1'b0, thr};
			if (!m_s11.armed)
				dut[i] = '0;
			else if (sum[i] > {2'b0, lim_q})
				dut[i] = DUTY_BITS'(lim_q);
			else
				dut[i] = DUTY_BITS'(sum[i][LIM_W-1:0]);
		end
		duty_d.duty_zero  = dut[0];
		duty_d.duty_one   = dut[1];
		duty_d.duty_two   = dut[2];
		duty_d.duty_three = dut[3];
	end

	// stage 12: output register
	mix_duty_t o_s12;

	always_ff @(posedge clk) begin
		if (en_o) o_s12 <= duty_d;
	end

	assign duty       = o_s12;
	assign duty_valid = v_o_s12;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (duty_valid && duty_stall))
		else $error("input stalled without a full pipe behind a stalled output");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(v_m_s11 && en_o) |=> duty_valid)
		else $error("item lost between thrust stage and output");

	a_disarm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_m_s11 && en_o && !m_s11.armed) |=> (duty == '0))
		else $error("disarmed item gave nonzero duty");

endmodule

/* verif/qmm_duty_checker.sv */
module qmm_duty_checker import qmm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  mix_cmd_t              cmd,
	input  logic                  duty_valid,
	input  logic                  duty_stall,
	input  mix_duty_t             duty,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatch_cnt,
	output int                    pending_cnt
);

	logic [LIM_W-1:0]          lim_q;
	logic [SHARE_W-1:0]        share_q;
	logic [KNEE_W-1:0]         knee_q;
	logic signed [TRIM_W-1:0]  trim_q [4];

	mix_duty_t duty_expect_q [$];
	mix_duty_t want;
	int        err_n;

	function automatic mix_duty_t predict_duties(mix_cmd_t c);
		longint    lim, share, knee, t, curve, thrust, ctl_cap, m, unit;
		longint    r, p, y;
		longint    mix_sum [4];
		longint    trim [4];
		logic [DUTY_BITS-1:0] dv [4];
		mix_duty_t d;
		lim   = lim_q;
		share = share_q;
		knee  = knee_q;
		t     = c.thrust_cmd;
		r     = $signed(c.roll_ctl);
		p     = $signed(c.pitch_ctl);
		y     = $signed(c.yaw_ctl);
		unit  = longint'(1) << CTL_FRAC_BITS;
		if (!c.armed)
			return '0;
		if (t < knee)
			curve = 3 * t;
		else if (lim <= knee)
			curve = lim;
		else
			curve = ((lim - 3 * knee) * (t - knee) + 3 * knee * (lim - knee)) / (lim - knee);
		// upper bound first, then floor at zero
		thrust = (curve * share) / 256;
		if (thrust > (lim * share) / 256)
			thrust = (lim * share) / 256;
		if (thrust < 0)
			thrust = 0;
		ctl_cap = (lim * (256 - share)) / 256;
		for (int i = 0; i < 4; i++)
			trim[i] = trim_q[i];
		mix_sum[0] =  r - p - y;
		mix_sum[1] =  r + p + y;
		mix_sum[2] = -r + p - y;
		mix_sum[3] = -r - p + y;
		for (int i = 0; i < 4; i++) begin
			m = (mix_sum[i] + trim[i] * unit) / unit;
			if (m > ctl_cap)
				m = ctl_cap;
			if (m < 0)
				m = 0;
			m = m + thrust;
			if (m > lim)
				m = lim;
			if (m < 0)
				m = 0;
			dv[i] = m[DUTY_BITS-1:0];
		end
		d.duty_zero  = dv[0];
		d.duty_one   = dv[1];
		d.duty_two   = dv[2];
		d.duty_three = dv[3];
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q        = RST_MOTOR_LIMIT;
			share_q      = RST_THRUST_SHARE;
			knee_q       = RST_KNEE_POINT;
			trim_q[0]    = RST_OFFSET_FL;
			trim_q[1]    = RST_OFFSET_FR;
			trim_q[2]    = RST_OFFSET_RR;
			trim_q[3]    = RST_OFFSET_RL;
			err_n        = 0;
			duty_expect_q.delete();
			mismatch_cnt <= 0;
			pending_cnt  <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MOTOR_LIMIT:  lim_q     = cfg_wdata[LIM_W-1:0];
					CFG_THRUST_SHARE: share_q   = cfg_wdata[SHARE_W-1:0];
					CFG_KNEE_POINT:   knee_q    = cfg_wdata[KNEE_W-1:0];
					CFG_OFFSET_FL:    trim_q[0] = cfg_wdata[TRIM_W-1:0];
					CFG_OFFSET_FR:    trim_q[1] = cfg_wdata[TRIM_W-1:0];
					CFG_OFFSET_RR:    trim_q[2] = cfg_wdata[TRIM_W-1:0];
					CFG_OFFSET_RL:    trim_q[3] = cfg_wdata[TRIM_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && !cmd_stall)
				duty_expect_q.push_back(predict_duties(cmd));
			if (duty_valid && !duty_stall) begin
				if (duty_expect_q.size() == 0) begin
					err_n++;
					if (err_n <= 10)
						$display("unexpected duty item: %0d %0d %0d %0d",
							duty.duty_zero, duty.duty_one, duty.duty_two, duty.duty_three);
				end else begin
					want = duty_expect_q.pop_front();
					if (duty.duty_zero !== want.duty_zero || duty.duty_one !== want.duty_one ||
					    duty.duty_two !== want.duty_two || duty.duty_three !== want.duty_three) begin
						err_n++;
						if (err_n <= 10)
							$display("duty mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								want.duty_zero, want.duty_one, want.duty_two, want.duty_three,
								duty.duty_zero, duty.duty_one, duty.duty_two, duty.duty_three);
					end
				end
			end
			mismatch_cnt <= err_n;
			pending_cnt  <= duty_expect_q.size();
		end
	end

endmodule

/* verif/tb_quad_motor_mixer.sv */
module tb_quad_motor_mixer;
	import qmm_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 175;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

	// kinds of register settings for the random phases
	localparam int SET_IN_RANGE = 0;
	localparam int SET_TOP      = 1;
	localparam int SET_BOTTOM   = 2;
	localparam int SET_ANY      = 3;

	typedef struct packed {
		logic [LIM_W-1:0]         lim;
		logic [SHARE_W-1:0]       share;
		logic [KNEE_W-1:0]        knee;
		logic [3:0][TRIM_W-1:0]   trim;
	} mixer_cfg_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	mix_cmd_t              cmd;
	logic                  duty_valid;
	logic                  duty_stall;
	mix_duty_t             duty;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatch_cnt;
	int                    pending_cnt;
	int                    cycle_cnt;
	mixer_cfg_t            cur_cfg;

	quad_motor_mixer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.duty_valid (duty_valid),
		.duty_stall (duty_stall),
		.duty       (duty),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	qmm_duty_checker mixer_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.duty_valid   (duty_valid),
		.duty_stall   (duty_stall),
		.duty         (duty),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatch_cnt (mismatch_cnt),
		.pending_cnt  (pending_cnt)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// receiver backpressure: open stretches half the time, otherwise mostly short stalls and some long ones
	initial begin
		int sel;
		int n;
		duty_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				duty_stall <= 1'b0;
				n = $urandom_range(1, 30);
			end else if (sel < 90) begin
				duty_stall <= 1'b1;
				n = $urandom_range(1, 3);
			end else begin
				duty_stall <= 1'b1;
				n = $urandom_range(10, 60);
			end
			repeat (n) @(posedge clk);
		end
	end

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		else if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [CTL_W-1:0] rand_ctl();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			return CTL_W'(int'($urandom_range(0, 2047)) - 1024);
		else if (sel < 65)
			return CTL_W'(int'($urandom_range(0, 16383)) - 8192);
		else if (sel < 92)
			return CTL_W'($urandom_range(0, 65535));
		case ($urandom_range(0, 3))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'shffff;
		endcase
	endfunction

	function automatic mix_cmd_t rand_cmd(logic [KNEE_W-1:0] knee);
		mix_cmd_t c;
		int       t;
		c.armed = ($urandom_range(0, 99) < 88);
		if ($urandom_range(0, 99) < 30) begin
			t = int'(knee) + int'($urandom_range(0, 6)) - 3;
			if (t < 0)
				t = 0;
		end else begin
			t = $urandom_range(0, 255);
		end
		c.thrust_cmd = 8'(t);
		c.roll_ctl   = rand_ctl();
		c.pitch_ctl  = rand_ctl();
		c.yaw_ctl    = rand_ctl();
		return c;
	endfunction

	function automatic mix_cmd_t mk_cmd(bit armed, int t, int r, int p, int y);
		mix_cmd_t c;
		c.armed      = armed;
		c.thrust_cmd = 8'(t);
		c.roll_ctl   = CTL_W'(r);
		c.pitch_ctl  = CTL_W'(p);
		c.yaw_ctl    = CTL_W'(y);
		return c;
	endfunction

	function automatic mixer_cfg_t mk_cfg(int lim, int share, int knee, int trim_v);
		mixer_cfg_t s;
		s.lim   = LIM_W'(lim);
		s.share = SHARE_W'(share);
		s.knee  = KNEE_W'(knee);
		for (int i = 0; i < 4; i++)
			s.trim[i] = TRIM_W'(trim_v);
		return s;
	endfunction

	function automatic mixer_cfg_t rand_mixer_cfg(int kind);
		mixer_cfg_t s;
		case (kind)
			SET_TOP:    s = mk_cfg(255, 256, 40, 63);
			SET_BOTTOM: s = mk_cfg(121, 0, 1, -64);
			SET_ANY: begin
				s.lim   = LIM_W'($urandom_range(0, 255));
				s.share = SHARE_W'($urandom_range(0, 511));
				s.knee  = KNEE_W'($urandom_range(0, 63));
			end
			default: begin
				s.lim   = LIM_W'($urandom_range(121, 255));
				s.share = SHARE_W'($urandom_range(0, 256));
				s.knee  = KNEE_W'($urandom_range(1, 40));
			end
		endcase
		if (kind == SET_ANY || kind == SET_IN_RANGE)
			for (int i = 0; i < 4; i++)
				s.trim[i] = TRIM_W'($urandom_range(0, 127));
		return s;
	endfunction

	// upper data bits beyond each register's width carry junk
	task automatic write_mixer_cfg(input mixer_cfg_t s);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MOTOR_LIMIT;
		cfg_wdata <= {1'($urandom), s.lim};
		@(posedge clk);
		cfg_index <= CFG_THRUST_SHARE;
		cfg_wdata <= s.share;
		@(posedge clk);
		cfg_index <= CFG_KNEE_POINT;
		cfg_wdata <= {3'($urandom), s.knee};
		@(posedge clk);
		cfg_index <= CFG_OFFSET_FL;
		cfg_wdata <= {2'($urandom), s.trim[0]};
		@(posedge clk);
		cfg_index <= CFG_OFFSET_FR;
		cfg_wdata <= {2'($urandom), s.trim[1]};
		@(posedge clk);
		cfg_index <= CFG_OFFSET_RR;
		cfg_wdata <= {2'($urandom), s.trim[2]};
		@(posedge clk);
		cfg_index <= CFG_OFFSET_RL;
		cfg_wdata <= {2'($urandom), s.trim[3]};
		@(posedge clk);
		// unused index must leave every register alone
		cfg_index <= CFG_SPARE_IDX;
		cfg_wdata <= CFG_DATA_W'($urandom_range(0, 511));
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_cfg = s;
	endtask

	task automatic send_cmd(input mix_cmd_t c, input int gap);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			cmd       <= rand_cmd(cur_cfg.knee);
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_cnt != 0);
	endtask

	initial begin
		int kind;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		cur_cfg   = mk_cfg(RST_MOTOR_LIMIT, RST_THRUST_SHARE, RST_KNEE_POINT, 0);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults straight out of reset
		send_cmd(mk_cmd(0, 255, 32767, -32768, -1), pick_gap());
		send_cmd(mk_cmd(1, 0, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 39, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 40, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 255, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 128, 32767, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 128, -32768, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 200, 0, 32767, -32768), pick_gap());
		send_cmd(mk_cmd(1, 100, 100, -37, 21), pick_gap());
		send_cmd(mk_cmd(1, 255, -32768, -32768, -32768), pick_gap());
		cmd_valid <= 1'b0;

		// limit at or below the knee
		wait_idle();
		write_mixer_cfg(mk_cfg(30, 166, 40, 0));
		send_cmd(mk_cmd(1, 39, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 40, 300, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 255, -300, 45, 0), pick_gap());
		cmd_valid <= 1'b0;

		// share above one: control terms all clamp to zero
		wait_idle();
		write_mixer_cfg(mk_cfg(255, 300, 40, 63));
		send_cmd(mk_cmd(1, 200, 500, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 10, -500, 200, 9), pick_gap());
		cmd_valid <= 1'b0;

		// limit below three times the knee: curve goes negative
		wait_idle();
		write_mixer_cfg(mk_cfg(45, 256, 40, -64));
		send_cmd(mk_cmd(1, 255, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 60, 1000, 0, 0), pick_gap());
		cmd_valid <= 1'b0;

		wait_idle();
		write_mixer_cfg(mk_cfg(121, 0, 1, 17));
		send_cmd(mk_cmd(1, 0, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 255, 2000, 0, 0), pick_gap());
		cmd_valid <= 1'b0;

		wait_idle();
		write_mixer_cfg(mk_cfg(255, 511, 63, -1));
		send_cmd(mk_cmd(1, 255, 0, 0, 0), pick_gap());
		send_cmd(mk_cmd(1, 62, -7, 3, 1), pick_gap());
		cmd_valid <= 1'b0;

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph % 2)
				kind = SET_IN_RANGE;
			else if (ph == 0)
				kind = SET_TOP;
			else if (ph == 2)
				kind = SET_BOTTOM;
			else
				kind = SET_ANY;
			wait_idle();
			write_mixer_cfg(rand_mixer_cfg(kind));
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_cmd(rand_cmd(cur_cfg.knee), ((k / 40) % 3 == 0) ? 0 : pick_gap());
			cmd_valid <= 1'b0;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
rtl/qmm_pkg.sv
rtl/quad_motor_mixer.sv
verif/qmm_duty_checker.sv
verif/tb_quad_motor_mixer.sv
